### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Default form: clk_i and rst_ni of the enclosing module
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

### hdl/hssg_pkg.sv
// ----------------------------------------------------------------------------
// hssg_pkg
// Types and constants shared by the halo strip scatter address generator.
// ----------------------------------------------------------------------------
package hssg_pkg;

  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [CfgIdxW-1:0] {
    RegRowLength  = 3'd0,
    RegWindowBase = 3'd1,
    RegColStart   = 3'd2,
    RegColCount   = 3'd3,
    RegColLimit   = 3'd4,
    RegRowStart   = 3'd5,
    RegRowCount   = 3'd6,
    RegRowLimit   = 3'd7
  } hssg_reg_e;

  typedef struct packed {
    logic [15:0] row_length;
    logic [31:0] window_base;
    logic [16:0] col_start;
    logic [15:0] col_count;
    logic [15:0] col_limit;
    logic [16:0] row_start;
    logic [15:0] row_count;
    logic [15:0] row_limit;
  } hssg_cfg_t;

  // Queue entry, less the parameter-wide row base which travels beside it
  typedef struct packed {
    logic [15:0] level;
    logic [15:0] col_cnt;
    logic [63:0] sample;
  } hssg_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } hssg_q_stat_t;

endpackage

### hdl/hssg_in_if.sv
// ----------------------------------------------------------------------------
// hssg_in_if
// Sample input channel: one local data point per beat.
// ----------------------------------------------------------------------------
interface hssg_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] sample_bits;
  logic        end_of_message;

  modport source (output valid, sample_bits, end_of_message, input ready);
  modport sink   (input valid, sample_bits, end_of_message, output ready);
endinterface

### hdl/hssg_out_if.sv
// ----------------------------------------------------------------------------
// hssg_out_if
// Result channel: one kept point with its level and global index per beat.
// ----------------------------------------------------------------------------
interface hssg_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] level;
  logic [31:0] cell_index;
  logic [63:0] sample_out;

  modport source (output valid, level, cell_index, sample_out, input ready);
  modport sink   (input valid, level, cell_index, sample_out, output ready);
endinterface

### hdl/hssg_cfg_if.sv
// ----------------------------------------------------------------------------
// hssg_cfg_if
// Configuration write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface hssg_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hssg_pkg::CfgIdxW-1:0]  index;
  logic [hssg_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/hssg_front.sv
// ----------------------------------------------------------------------------
// hssg_front
// Register file, window counters and halo classification; pushes kept beats.
// ----------------------------------------------------------------------------
module hssg_front #(
  parameter int unsigned INDEX_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  hssg_cfg_if.sink                 cfg_i,
  hssg_in_if.sink                  sample_i,
  input  hssg_pkg::hssg_q_stat_t   q_stat_i,
  output logic                     push_o,
  output hssg_pkg::hssg_item_t     item_o,
  output logic [INDEX_WIDTH-1:0]   row_base_o
);
  import hssg_pkg::*;

  hssg_cfg_t cfg_d, cfg_q;

  logic                   primed_d, primed_q;
  logic signed [17:0]     col_pos_d, col_pos_q, row_pos_d, row_pos_q;
  logic [15:0]            col_cnt_d, col_cnt_q, row_cnt_d, row_cnt_q;
  logic [15:0]            level_d, level_q;
  logic [INDEX_WIDTH-1:0] row_base_d, row_base_q;

  logic signed [17:0]     col_start_x, row_start_x, col_limit_x, row_limit_x;
  logic signed [17:0]     col_pos_cur, row_pos_cur;
  logic [15:0]            col_cnt_cur, row_cnt_cur, level_cur;
  logic [INDEX_WIDTH-1:0] row_base_cur, base_ext;
  logic signed [31:0]     window_base_s;
  logic [15:0]            ccount, rcount;
  logic                   col_wrap, row_wrap, keep, accept;

  // Configuration decode
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (hssg_reg_e'(cfg_i.index))
        RegRowLength:  cfg_d.row_length  = cfg_i.data[15:0];
        RegWindowBase: cfg_d.window_base = cfg_i.data;
        RegColStart:   cfg_d.col_start   = cfg_i.data[16:0];
        RegColCount:   cfg_d.col_count   = cfg_i.data[15:0];
        RegColLimit:   cfg_d.col_limit   = cfg_i.data[15:0];
        RegRowStart:   cfg_d.row_start   = cfg_i.data[16:0];
        RegRowCount:   cfg_d.row_count   = cfg_i.data[15:0];
        RegRowLimit:   cfg_d.row_limit   = cfg_i.data[15:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{row_length: 16'd1, window_base: 32'd0, col_start: 17'd0,
                 col_count: 16'd1, col_limit: 16'd0, row_start: 17'd0,
                 row_count: 16'd1, row_limit: 16'd0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Widened views of the registers
  assign col_start_x   = {cfg_q.col_start[16], cfg_q.col_start};
  assign row_start_x   = {cfg_q.row_start[16], cfg_q.row_start};
  assign col_limit_x   = {2'b00, cfg_q.col_limit};
  assign row_limit_x   = {2'b00, cfg_q.row_limit};
  assign window_base_s = cfg_q.window_base;
  assign base_ext      = INDEX_WIDTH'(window_base_s);
  assign ccount        = (cfg_q.col_count == 16'd0) ? 16'd1 : cfg_q.col_count;
  assign rcount        = (cfg_q.row_count == 16'd0) ? 16'd1 : cfg_q.row_count;

  // First beat of a message sees freshly loaded counters
  assign col_pos_cur  = primed_q ? col_pos_q  : col_start_x;
  assign row_pos_cur  = primed_q ? row_pos_q  : row_start_x;
  assign col_cnt_cur  = primed_q ? col_cnt_q  : 16'd0;
  assign row_cnt_cur  = primed_q ? row_cnt_q  : 16'd0;
  assign level_cur    = primed_q ? level_q    : 16'd0;
  assign row_base_cur = primed_q ? row_base_q : base_ext;

  assign keep = !col_pos_cur[17] && (col_pos_cur < col_limit_x) &&
                !row_pos_cur[17] && (row_pos_cur < row_limit_x);

  assign col_wrap = ({1'b0, col_cnt_cur} + 17'd1) >= {1'b0, ccount};
  assign row_wrap = ({1'b0, row_cnt_cur} + 17'd1) >= {1'b0, rcount};

  assign sample_i.ready = !q_stat_i.full;
  assign accept         = sample_i.valid && sample_i.ready;

  always_comb begin
    primed_d   = primed_q;
    col_pos_d  = col_pos_q;
    row_pos_d  = row_pos_q;
    col_cnt_d  = col_cnt_q;
    row_cnt_d  = row_cnt_q;
    level_d    = level_q;
    row_base_d = row_base_q;
    if (accept) begin
      primed_d   = !sample_i.end_of_message;
      col_pos_d  = col_pos_cur + 18'sd1;
      col_cnt_d  = col_cnt_cur + 16'd1;
      row_pos_d  = row_pos_cur;
      row_cnt_d  = row_cnt_cur;
      level_d    = level_cur;
      row_base_d = row_base_cur;
      if (col_wrap) begin
        col_pos_d = col_start_x;
        col_cnt_d = 16'd0;
        if (row_wrap) begin
          // next level: rewind to window origin
          row_pos_d  = row_start_x;
          row_cnt_d  = 16'd0;
          row_base_d = base_ext;
          level_d    = level_cur + 16'd1;
        end else begin
          row_pos_d  = row_pos_cur + 18'sd1;
          row_cnt_d  = row_cnt_cur + 16'd1;
          row_base_d = row_base_cur + INDEX_WIDTH'(cfg_q.row_length);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q   <= 1'b0;
      col_pos_q  <= '0;
      row_pos_q  <= '0;
      col_cnt_q  <= '0;
      row_cnt_q  <= '0;
      level_q    <= '0;
      row_base_q <= '0;
    end else begin
      primed_q   <= primed_d;
      col_pos_q  <= col_pos_d;
      row_pos_q  <= row_pos_d;
      col_cnt_q  <= col_cnt_d;
      row_cnt_q  <= row_cnt_d;
      level_q    <= level_d;
      row_base_q <= row_base_d;
    end
  end

  // Halo beats are taken but dropped here
  assign push_o     = accept && keep;
  assign item_o     = '{level: level_cur, col_cnt: col_cnt_cur, sample: sample_i.sample_bits};
  assign row_base_o = row_base_cur;

endmodule

### hdl/hssg_fifo.sv
// ----------------------------------------------------------------------------
// hssg_fifo
// Short register queue between the front and back halves.
// ----------------------------------------------------------------------------
module hssg_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [Width-1:0]       data_i,
  input  logic                   pop_i,
  output logic [Width-1:0]       data_o,
  output hssg_pkg::hssg_q_stat_t stat_o
);
  import hssg_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [CntW-1:0]  count_d, count_q;
  logic             do_push, do_pop;

  assign stat_o.full  = (count_q == CntW'(Depth));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### hdl/hssg_back.sv
// ----------------------------------------------------------------------------
// hssg_back
// Forms the global cell index and holds the result in an output register.
// ----------------------------------------------------------------------------
module hssg_back #(
  parameter int unsigned INDEX_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hssg_pkg::hssg_q_stat_t q_stat_i,
  input  hssg_pkg::hssg_item_t   item_i,
  input  logic [INDEX_WIDTH-1:0] row_base_i,
  output logic                   pop_o,
  hssg_out_if.source             result_o
);
  import hssg_pkg::*;

  localparam int unsigned ExtW = (INDEX_WIDTH > 32) ? INDEX_WIDTH : 32;

  logic [INDEX_WIDTH-1:0] cell_sum;
  logic [ExtW-1:0]        cell_ext;
  logic                   valid_d, valid_q;
  logic [15:0]            level_q;
  logic [31:0]            cell_q;
  logic [63:0]            sample_q;

  // Index wraps at the index width, then is zero-extended or cut to the port width
  assign cell_sum = row_base_i + INDEX_WIDTH'(item_i.col_cnt);
  assign cell_ext = ExtW'(cell_sum);

  // Advance when the output register is empty or being drained
  assign pop_o = !q_stat_i.empty && (!valid_q || result_o.ready);

  always_comb begin
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (result_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      level_q  <= item_i.level;
      cell_q   <= cell_ext[31:0];
      sample_q <= item_i.sample;
    end
  end

  assign result_o.valid      = valid_q;
  assign result_o.level      = level_q;
  assign result_o.cell_index = cell_q;
  assign result_o.sample_out = sample_q;

endmodule

### hdl/halo_strip_scatter_address_gen.sv
// ----------------------------------------------------------------------------
// halo_strip_scatter_address_gen
// Scatters a halo-padded data window into global field indices.
// ----------------------------------------------------------------------------
// Usage:
//   sample_i takes one data word per beat, row-major over the window with
//   columns fastest, then rows, then levels; end_of_message marks the last
//   beat, after which the counters reload from the registers.
//   result_o gives one beat per interior point: level, global cell index
//   and the unchanged word. Halo points are accepted and dropped.
//   cfg_i writes register <index> with <data>; it is always ready. Write
//   only between messages, once all results have been taken.
// Timing:
//   One input beat per cycle while the queue is not full. A kept point is
//   written into the queue and then into the output register before it
//   appears on result_o.
// Reset:
//   Registers return to their defaults, queue and output register empty.
// Stall:
//   A two-entry queue and the output register absorb a stalled receiver;
//   sample_i.ready drops only when the queue is full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module halo_strip_scatter_address_gen #(
  parameter int unsigned INDEX_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hssg_cfg_if.sink    cfg_i,
  hssg_in_if.sink     sample_i,
  hssg_out_if.source  result_o
);
  import hssg_pkg::*;

  localparam int unsigned EntryW = $bits(hssg_item_t) + INDEX_WIDTH;

  hssg_q_stat_t           q_stat;
  hssg_item_t             item_in, item_out;
  logic [INDEX_WIDTH-1:0] row_base_in, row_base_out;
  logic [EntryW-1:0]      entry_in, entry_out;
  logic                   push, pop;

  hssg_front #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .sample_i   (sample_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .item_o     (item_in),
    .row_base_o (row_base_in)
  );

  assign entry_in = {item_in, row_base_in};

  hssg_fifo #(
    .Width (EntryW),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (entry_in),
    .pop_i  (pop),
    .data_o (entry_out),
    .stat_o (q_stat)
  );

  assign item_out     = entry_out[EntryW-1:INDEX_WIDTH];
  assign row_base_out = entry_out[INDEX_WIDTH-1:0];

  hssg_back #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (q_stat),
    .item_i     (item_out),
    .row_base_i (row_base_out),
    .pop_o      (pop),
    .result_o   (result_o)
  );

  `ASSERT_STD(a_push_fills_queue, push |=> !q_stat.empty, "pushed beat missing from queue")
  `ASSERT_STD(a_no_push_when_full, q_stat.full |-> !push, "push into full queue")
  `ASSERT_STD(a_result_from_pop, $rose(result_o.valid) |-> $past(pop), "result without dequeue")

endmodule
